[rtl/core/md5_pkg.sv]
// MD5 engine package: types, codes, round constants and round helper functions.
package md5_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [3:0]       widx_t;
    typedef logic [5:0]       round_t;
    typedef logic [3:0][31:0] chain_t;

    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hEFCDAB89;
    localparam word_t INIT_C = 32'h98BADCFE;
    localparam word_t INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // block word slots for the bit length and the block's last word
    localparam widx_t LEN_LO_IDX = 4'd14;
    localparam widx_t LAST_IDX   = 4'd15;

    localparam logic [2:0] MAX_BYTES = 3'd4;

    // floor(|sin(n+1)| * 2^32)
    localparam word_t SINE_ROM [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93ab39,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN_LO,
        S_LEN_HI,
        S_WAIT,
        S_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PRE,
        C_ROUND,
        C_CHAIN
    } cmp_state_t;

    typedef struct packed {
        logic start;
        logic chain_init;
    } cmp_ctrl_t;

    typedef struct packed {
        logic  en;
        widx_t addr;
        word_t data;
    } buf_wr_t;

    // message word used by a round
    function automatic widx_t msg_index(round_t r);
        widx_t s;
        s = r[3:0];
        case (r[5:4])
            2'd0:    msg_index = s;
            2'd1:    msg_index = widx_t'(s * 4'd5 + 4'd1);
            2'd2:    msg_index = widx_t'(s * 4'd3 + 4'd5);
            default: msg_index = widx_t'(s * 4'd7);
        endcase
    endfunction

    function automatic logic [4:0] rot_amount(round_t r);
        case ({r[5:4], r[1:0]})
            4'h0:    rot_amount = 5'd7;
            4'h1:    rot_amount = 5'd12;
            4'h2:    rot_amount = 5'd17;
            4'h3:    rot_amount = 5'd22;
            4'h4:    rot_amount = 5'd5;
            4'h5:    rot_amount = 5'd9;
            4'h6:    rot_amount = 5'd14;
            4'h7:    rot_amount = 5'd20;
            4'h8:    rot_amount = 5'd4;
            4'h9:    rot_amount = 5'd11;
            4'hA:    rot_amount = 5'd16;
            4'hB:    rot_amount = 5'd23;
            4'hC:    rot_amount = 5'd6;
            4'hD:    rot_amount = 5'd10;
            4'hE:    rot_amount = 5'd15;
            default: rot_amount = 5'd21;
        endcase
    endfunction

    function automatic word_t rotl(word_t x, logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        rotl = w[63:32];
    endfunction

    function automatic word_t round_mix(logic [1:0] p, word_t b, word_t c, word_t d);
        case (p)
            2'd0:    round_mix = (b & c) | (~b & d);
            2'd1:    round_mix = (d & b) | (~d & c);
            2'd2:    round_mix = b ^ c ^ d;
            default: round_mix = c ^ (b | ~d);
        endcase
    endfunction

endpackage

[rtl/core/md5_if.sv]
// MD5 engine stream interfaces: message word input and digest output.
interface md5_in_if
    import md5_pkg::*;
;
    logic       valid;
    logic       ready;
    word_t      data_word;
    logic [2:0] byte_count;
    logic       last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last_word,
                    output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

[rtl/core/md5_compress.sv]
// MD5 block buffer memory, 64-round compression loop and chaining values.
module md5_compress
    import md5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmp_ctrl_t ctrl,
    input  buf_wr_t   wr,
    output logic      done,
    output chain_t    chain
);

    word_t      buf_mem_reg [16];
    word_t      rd_data_reg;
    widx_t      rd_addr;

    cmp_state_t state_reg, state_next;
    round_t     round_reg, round_next;
    chain_t     work_reg, work_next;
    chain_t     chain_reg, chain_next;

    word_t      mix_val;
    word_t      sum_val;
    word_t      new_b;

    // block buffer: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            buf_mem_reg[wr.addr] <= wr.data;
        end
        rd_data_reg <= buf_mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= {INIT_D, INIT_C, INIT_B, INIT_A};
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = C_PRE;
                end
            end
            C_PRE:   state_next = C_ROUND;
            C_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = C_CHAIN;
                end
            end
            C_CHAIN: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // outputs: read address runs one round ahead of the datapath
    always_comb
    begin
        rd_addr = '0;
        done    = 1'b0;
        case (state_reg)
            C_PRE:   rd_addr = msg_index(round_reg);
            C_ROUND: rd_addr = msg_index(round_reg + 6'd1);
            C_CHAIN: done    = 1'b1;
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        mix_val = round_mix(round_reg[5:4], work_reg[1], work_reg[2], work_reg[3]);
        sum_val = work_reg[0] + mix_val + SINE_ROM[round_reg] + rd_data_reg;
        new_b   = work_reg[1] + rotl(sum_val, rot_amount(round_reg));
    end

    always_comb
    begin
        work_next  = work_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        case (state_reg)
            C_PRE:
            begin
                work_next  = chain_reg;
                round_next = '0;
            end
            C_ROUND:
            begin
                work_next  = {work_reg[2], work_reg[1], new_b, work_reg[3]};
                round_next = round_reg + 6'd1;
            end
            C_CHAIN:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
            default:
            begin
                if (ctrl.chain_init)
                begin
                    chain_next = {INIT_D, INIT_C, INIT_B, INIT_A};
                end
            end
        endcase
    end

    assign chain = chain_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == C_IDLE)
        else $error("compress start while busy");

    a_round_parked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != C_ROUND |-> round_reg == '0)
        else $error("round counter not parked outside rounds");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == C_IDLE && !done)
        else $error("compress did not return to idle after chain update");

    a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.chain_init |-> state_reg == C_IDLE)
        else $error("chain reload during compression");

endmodule

[rtl/core/md5_hash_engine_unit.sv]
// MD5 engine top level: byte packing, padding sequencer and digest output register.
//
// The engine takes little-endian message words (0 to 4 valid bytes each, packed
// back to back) and returns one 128-bit MD5 digest per message, on the word marked
// last. Each input beat is taken while the engine is idle; it packs into a 16-word
// block buffer memory. When the sixteenth word lands, the block is compressed by a
// single round unit that runs the 64 rounds one per cycle, fed by the buffer
// memory's registered read port, with a read setup state before the rounds and a
// state that folds into the chaining values after them; no beat is taken until the
// compression is done. The throughput of a steady stream of full words is set
// by the round loop. After the last beat the padding sequencer writes the pad and
// zero words (one per cycle, pausing while a block is compressed), the two length
// words and runs one or two more compressions; once the output register is free
// the digest moves into it, the chaining values reload, and the engine takes the
// next message while that digest still waits to be taken.
module md5_hash_engine_unit
    import md5_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);

    eng_state_t  state_reg, state_next;
    eng_state_t  ret_reg, ret_next;     // where to resume after a compression
    logic [23:0] acc_reg, acc_next;     // up to three pending bytes
    logic [1:0]  acc_cnt_reg, acc_cnt_next;
    widx_t       wi_reg, wi_next;       // next block word slot
    logic [63:0] total_reg, total_next; // message bytes so far

    logic        out_valid_reg;
    logic [63:0] dig_lo_reg;
    logic [63:0] dig_hi_reg;

    logic        in_fire;
    logic [2:0]  cnt;
    word_t       data_m;
    logic [55:0] shf;
    logic [55:0] merged;
    logic [2:0]  sum_cnt;
    word_t       pad_word;
    logic [63:0] bit_len;
    logic        out_free;
    logic        load_out;

    buf_wr_t     wr;
    cmp_ctrl_t   ctrl;
    logic        cmp_done;
    chain_t      chain;

    md5_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .wr    (wr),
        .done  (cmp_done),
        .chain (chain)
    );

    assign in_fire  = in_ch.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign bit_len  = {total_reg[60:0], 3'b000};

    // byte merge: pending bytes first, then the valid bytes of this beat
    always_comb
    begin
        cnt = (in_ch.byte_count > MAX_BYTES) ? MAX_BYTES : in_ch.byte_count;
        for (int i = 0; i < 4; i++)
        begin
            data_m[8*i +: 8] = (3'(i) < cnt) ? in_ch.data_word[8*i +: 8] : 8'h00;
        end
        case (acc_cnt_reg)
            2'd0:    shf = {24'h0, data_m};
            2'd1:    shf = {16'h0, data_m, 8'h0};
            2'd2:    shf = {8'h0, data_m, 16'h0};
            default: shf = {data_m, 24'h0};
        endcase
        merged  = shf | {32'h0, acc_reg};
        sum_cnt = {1'b0, acc_cnt_reg} + cnt;
        case (acc_cnt_reg)
            2'd0:    pad_word = {24'h0, PAD_MARK};
            2'd1:    pad_word = {16'h0, PAD_MARK, acc_reg[7:0]};
            2'd2:    pad_word = {8'h0, PAD_MARK, acc_reg[15:0]};
            default: pad_word = {PAD_MARK, acc_reg[23:0]};
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ch.ready     = 1'b0;
        wr              = '0;
        load_out        = 1'b0;
        ctrl.chain_init = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_fire && sum_cnt[2])
                begin
                    wr = '{en: 1'b1, addr: wi_reg, data: merged[31:0]};
                end
            end
            S_PAD:    wr = '{en: 1'b1, addr: wi_reg, data: pad_word};
            S_ZERO:
            begin
                if (wi_reg != LEN_LO_IDX)
                begin
                    wr = '{en: 1'b1, addr: wi_reg, data: '0};
                end
            end
            S_LEN_LO: wr = '{en: 1'b1, addr: wi_reg, data: bit_len[31:0]};
            S_LEN_HI: wr = '{en: 1'b1, addr: wi_reg, data: bit_len[63:32]};
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    ctrl.chain_init = 1'b1;
                end
            end
            default:  wr = '0;
        endcase
        // the block runs whenever its last word is written
        ctrl.start = wr.en && (wr.addr == LAST_IDX);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (ctrl.start)
                    begin
                        state_next = S_WAIT;
                        ret_next   = in_ch.last_word ? S_PAD : S_IDLE;
                    end
                    else if (in_ch.last_word)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                state_next = ctrl.start ? S_WAIT : S_ZERO;
                ret_next   = S_ZERO;
            end
            S_ZERO:
            begin
                if (wi_reg == LEN_LO_IDX)
                begin
                    state_next = S_LEN_LO;
                end
                else if (ctrl.start)
                begin
                    state_next = S_WAIT;
                    ret_next   = S_ZERO;
                end
            end
            S_LEN_LO: state_next = S_LEN_HI;
            S_LEN_HI:
            begin
                state_next = S_WAIT;
                ret_next   = S_DONE;
            end
            S_WAIT:
            begin
                if (cmp_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // packing registers
    always_comb
    begin
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        total_next   = total_reg;
        wi_next      = wr.en ? wi_reg + 4'd1 : wi_reg;
        if (in_fire)
        begin
            total_next   = total_reg + 64'(cnt);
            acc_cnt_next = sum_cnt[1:0];
            acc_next     = sum_cnt[2] ? merged[55:32] : merged[23:0];
        end
        else if (state_reg == S_PAD)
        begin
            acc_next     = '0;
            acc_cnt_next = '0;
        end
        else if (load_out)
        begin
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            acc_reg       <= '0;
            acc_cnt_reg   <= '0;
            wi_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            acc_reg     <= acc_next;
            acc_cnt_reg <= acc_cnt_next;
            wi_reg      <= wi_next;
            total_reg   <= total_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // digest output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dig_lo_reg <= {chain[1], chain[0]};
            dig_hi_reg <= {chain[3], chain[2]};
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.digest_low  = dig_lo_reg;
    assign out_ch.digest_high = dig_hi_reg;

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> !wr.en)
        else $error("block buffer written during compression");

    a_slot_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> wi_reg == '0)
        else $error("word slot not wrapped after a full block");

    a_pad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PAD |=> acc_cnt_reg == '0)
        else $error("pending bytes left after pad word");

    a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("digest shown outside message end");

endmodule
